// File: rtl/arcc_pkg.sv
// Shared types, constants and helper functions of the access run coalesce counter.
`default_nettype none
package arcc_pkg;

  localparam int MAX_BLOCK_INSTS = 4096;
  localparam int CNT_W = $clog2(MAX_BLOCK_INSTS + 1);
  localparam int OFFSET_WIDTH = 16;
  localparam int NEXT_W = OFFSET_WIDTH + 1;
  localparam int SIZE_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_WORD = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] SIZE_DWORD = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] SIZE_QWORD = SIZE_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_INSTS);
  localparam logic [CNT_W-1:0] MIN_RUN = CNT_W'(2);

  typedef struct packed {
    logic                    is_access;
    logic                    is_store;
    logic [OFFSET_WIDTH-1:0] offset;
    logic [SIZE_W-1:0]       size_bytes;
    logic                    stores_prior_load;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] sequences;
    logic [CNT_W-1:0] ld_pairs;
    logic [CNT_W-1:0] st_pairs;
    logic [CNT_W-1:0] repeat_hits;
    logic [CNT_W-1:0] saved_count;
  } counts_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [CNT_W-1:0] a);
    logic [CNT_W:0] s;
    s = {1'b0, v} + {1'b0, a};
    if (s > {1'b0, CNT_MAX}) begin
      sat_add = CNT_MAX;
    end else begin
      sat_add = s[CNT_W-1:0];
    end
  endfunction

  function automatic logic pairable(input logic [SIZE_W-1:0] size);
    pairable = (size == SIZE_WORD) || (size == SIZE_DWORD) || (size == SIZE_QWORD);
  endfunction

endpackage
`default_nettype wire

// File: rtl/arcc_core.sv
// Run tracking state, same-offset detection and saturating counters.
`default_nettype none
module arcc_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_fire,
  input  wire arcc_pkg::item_t  item,
  output logic                  res_valid,
  output arcc_pkg::counts_t     res
);

  logic                                prev_valid_r, prev_valid_nxt;
  logic                                prev_store_r, prev_store_nxt;
  logic [arcc_pkg::OFFSET_WIDTH-1:0]   prev_offset_r, prev_offset_nxt;
  logic [arcc_pkg::SIZE_W-1:0]         prev_size_r, prev_size_nxt;
  logic                                run_is_store_r, run_is_store_nxt;
  logic [arcc_pkg::SIZE_W-1:0]         run_sz_r, run_sz_nxt;
  logic [arcc_pkg::NEXT_W-1:0]         run_next_offset_r, run_next_offset_nxt;
  logic [arcc_pkg::CNT_W-1:0]          run_length_r, run_length_nxt;
  arcc_pkg::counts_t                   cnt_r, cnt_nxt;

  logic                                same_hit;
  logic                                same_safe;
  logic                                extend;
  logic [arcc_pkg::CNT_W-1:0]          run_len_inc;
  logic [arcc_pkg::CNT_W-1:0]          flush_len;
  logic [arcc_pkg::CNT_W-1:0]          pairs;
  logic                                do_flush;
  logic [arcc_pkg::CNT_W-1:0]          saved_mid;
  logic [arcc_pkg::NEXT_W-1:0]         size_ext;
  logic [arcc_pkg::NEXT_W-1:0]         off_ext;

  always_comb begin
    size_ext = arcc_pkg::NEXT_W'(item.size_bytes);
    off_ext = arcc_pkg::NEXT_W'(item.offset);
    same_hit = item.is_access && prev_valid_r && (prev_offset_r == item.offset) &&
               (prev_size_r == item.size_bytes);
    same_safe = prev_store_r || !item.is_store || item.stores_prior_load;
    extend = item.is_access && (run_length_r != '0) && (item.is_store == run_is_store_r) &&
             (item.size_bytes == run_sz_r) && arcc_pkg::pairable(item.size_bytes) &&
             (off_ext == run_next_offset_r);
    run_len_inc = arcc_pkg::sat_add(run_length_r, arcc_pkg::CNT_W'(1));

    // At most one run is flushed per word: a new run holds at most one access.
    if (!item.is_access) begin
      flush_len = run_length_r;
    end else if (extend) begin
      flush_len = item.last ? run_len_inc : '0;
    end else begin
      flush_len = run_length_r;
    end
    do_flush = flush_len >= arcc_pkg::MIN_RUN;
    pairs = flush_len >> 1;

    cnt_nxt = cnt_r;
    saved_mid = cnt_r.saved_count;
    if (same_hit && same_safe) begin
      cnt_nxt.repeat_hits = arcc_pkg::sat_add(cnt_r.repeat_hits, arcc_pkg::CNT_W'(1));
      saved_mid = arcc_pkg::sat_add(cnt_r.saved_count, arcc_pkg::CNT_W'(1));
    end
    cnt_nxt.saved_count = saved_mid;
    if (do_flush) begin
      cnt_nxt.sequences = arcc_pkg::sat_add(cnt_r.sequences, arcc_pkg::CNT_W'(1));
      cnt_nxt.saved_count = arcc_pkg::sat_add(saved_mid, pairs);
      if (run_is_store_r) begin
        cnt_nxt.st_pairs = arcc_pkg::sat_add(cnt_r.st_pairs, pairs);
      end else begin
        cnt_nxt.ld_pairs = arcc_pkg::sat_add(cnt_r.ld_pairs, pairs);
      end
    end

    prev_valid_nxt = prev_valid_r;
    prev_store_nxt = prev_store_r;
    prev_offset_nxt = prev_offset_r;
    prev_size_nxt = prev_size_r;
    run_is_store_nxt = run_is_store_r;
    run_sz_nxt = run_sz_r;
    run_next_offset_nxt = run_next_offset_r;
    run_length_nxt = run_length_r;
    if (!item.is_access) begin
      prev_valid_nxt = 1'b0;
      run_length_nxt = '0;
    end else begin
      prev_valid_nxt = 1'b1;
      prev_store_nxt = item.is_store;
      prev_offset_nxt = item.offset;
      prev_size_nxt = item.size_bytes;
      if (extend) begin
        run_length_nxt = run_len_inc;
        run_next_offset_nxt = run_next_offset_r + size_ext;
      end else begin
        run_is_store_nxt = item.is_store;
        run_sz_nxt = item.size_bytes;
        run_next_offset_nxt = off_ext + size_ext;
        run_length_nxt = arcc_pkg::pairable(item.size_bytes) ? arcc_pkg::CNT_W'(1) : '0;
      end
    end

    res_valid = item_fire && item.last;
    res = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (item_fire && item.last)) begin
      prev_valid_r <= 1'b0;
      prev_store_r <= 1'b0;
      prev_offset_r <= '0;
      prev_size_r <= '0;
      run_is_store_r <= 1'b0;
      run_sz_r <= '0;
      run_next_offset_r <= '0;
      run_length_r <= '0;
      cnt_r <= '0;
    end else if (item_fire) begin
      prev_valid_r <= prev_valid_nxt;
      prev_store_r <= prev_store_nxt;
      prev_offset_r <= prev_offset_nxt;
      prev_size_r <= prev_size_nxt;
      run_is_store_r <= run_is_store_nxt;
      run_sz_r <= run_sz_nxt;
      run_next_offset_r <= run_next_offset_nxt;
      run_length_r <= run_length_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/access_run_coalesce_counter_unit.sv
// Top level of the access run coalesce counter with input and result registers.
//
// The input channel takes one instruction word per cycle (in_valid/in_ready).
// Each word describes one instruction of a block: whether it is a state load
// or store, its offset and size, and whether it is the last of the block.
// The result channel (out_valid/out_ready) carries one word per block, holding
// the five coalescing counts, produced by the word marked last.
// A word is held in the input register and then processed into the run state
// and counters; the result register takes a result when its last word leaves
// the input register, which needs the result register free or read. Throughput
// is one word per cycle while no last word waits, as each update takes one word.
// When the receiver stalls with a result pending, words that are not last keep
// flowing; a last word waits in the input register until the result register
// frees, and the input then fills and holds in_ready low.
// Reset clears the run state, all counters and both valid flags.
`default_nettype none
module access_run_coalesce_counter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_is_access,
  input  wire logic                              in_is_store,
  input  wire logic [arcc_pkg::OFFSET_WIDTH-1:0] in_offset,
  input  wire logic [arcc_pkg::SIZE_W-1:0]       in_size_bytes,
  input  wire logic                              in_stores_prior_load,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [arcc_pkg::CNT_W-1:0]             out_sequences,
  output logic [arcc_pkg::CNT_W-1:0]             out_ld_pairs,
  output logic [arcc_pkg::CNT_W-1:0]             out_st_pairs,
  output logic [arcc_pkg::CNT_W-1:0]             out_repeat_hits,
  output logic [arcc_pkg::CNT_W-1:0]             out_saved_count
);

  logic              s1_valid_r;
  arcc_pkg::item_t   s1_item_r;
  logic              s1_fire;
  logic              out_valid_r;
  arcc_pkg::counts_t out_cnt_r;
  logic              res_valid;
  arcc_pkg::counts_t res;

  assign s1_fire = s1_valid_r && (!s1_item_r.last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.is_access <= in_is_access;
      s1_item_r.is_store <= in_is_store;
      s1_item_r.offset <= in_offset;
      s1_item_r.size_bytes <= in_size_bytes;
      s1_item_r.stores_prior_load <= in_stores_prior_load;
      s1_item_r.last <= in_last;
    end
  end

  arcc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (s1_fire),
    .item      (s1_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_cnt_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sequences = out_cnt_r.sequences;
  assign out_ld_pairs = out_cnt_r.ld_pairs;
  assign out_st_pairs = out_cnt_r.st_pairs;
  assign out_repeat_hits = out_cnt_r.repeat_hits;
  assign out_saved_count = out_cnt_r.saved_count;

endmodule
`default_nettype wire

// File: tb/access_run_coalesce_counter_unit_tb.sv
// Self-checking testbench for the access run coalesce counter unit.
`default_nettype none
module access_run_coalesce_counter_unit_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_is_access = 1'b0;
  logic in_is_store = 1'b0;
  logic [arcc_pkg::OFFSET_WIDTH-1:0] in_offset = '0;
  logic [arcc_pkg::SIZE_W-1:0] in_size_bytes = '0;
  logic in_stores_prior_load = 1'b0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [arcc_pkg::CNT_W-1:0] out_sequences;
  logic [arcc_pkg::CNT_W-1:0] out_ld_pairs;
  logic [arcc_pkg::CNT_W-1:0] out_st_pairs;
  logic [arcc_pkg::CNT_W-1:0] out_repeat_hits;
  logic [arcc_pkg::CNT_W-1:0] out_saved_count;

  access_run_coalesce_counter_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_is_access(in_is_access),
    .in_is_store(in_is_store),
    .in_offset(in_offset),
    .in_size_bytes(in_size_bytes),
    .in_stores_prior_load(in_stores_prior_load),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sequences(out_sequences),
    .out_ld_pairs(out_ld_pairs),
    .out_st_pairs(out_st_pairs),
    .out_repeat_hits(out_repeat_hits),
    .out_saved_count(out_saved_count)
  );

  always #2 clk = ~clk;

  arcc_pkg::item_t pending[$];
  arcc_pkg::counts_t block_counts[$];
  arcc_pkg::item_t on_bus;
  int mismatches = 0;
  logic quiet = 1'b0;
  int src_gap = 0;
  int src_pct = 0;
  int src_tick = 0;
  int snk_gap = 0;
  int snk_pct = 0;
  int snk_tick = 0;
  bit emitted;
  arcc_pkg::counts_t predicted;
  arcc_pkg::counts_t seen_counts;
  arcc_pkg::counts_t want;

  logic seen_valid;
  logic seen_store;
  logic [arcc_pkg::OFFSET_WIDTH-1:0] seen_offset;
  logic [arcc_pkg::SIZE_W-1:0] seen_size;
  logic run_dir;
  logic [arcc_pkg::SIZE_W-1:0] run_sz;
  logic [arcc_pkg::NEXT_W-1:0] run_next;
  logic [arcc_pkg::CNT_W-1:0] run_len;
  arcc_pkg::counts_t tally;

  function automatic logic [arcc_pkg::CNT_W-1:0] sat_sum(
      input logic [arcc_pkg::CNT_W-1:0] v, input logic [arcc_pkg::CNT_W-1:0] a);
    int unsigned s;
    s = v + a;
    return (s > arcc_pkg::MAX_BLOCK_INSTS) ? arcc_pkg::CNT_MAX : arcc_pkg::CNT_W'(s);
  endfunction

  function automatic bit pairable_size(input logic [arcc_pkg::SIZE_W-1:0] sz);
    return sz == arcc_pkg::SIZE_WORD || sz == arcc_pkg::SIZE_DWORD ||
           sz == arcc_pkg::SIZE_QWORD;
  endfunction

  function automatic logic [arcc_pkg::SIZE_W-1:0] pick_pairable();
    case ($urandom_range(0, 2))
      0: return arcc_pkg::SIZE_WORD;
      1: return arcc_pkg::SIZE_DWORD;
      default: return arcc_pkg::SIZE_QWORD;
    endcase
  endfunction

  function automatic logic [arcc_pkg::OFFSET_WIDTH-1:0] random_offset();
    if ($urandom_range(0, 3) == 0) begin
      return 16'hFFFF - 16'($urandom_range(0, 40));
    end
    return 16'($urandom);
  endfunction

  function automatic int idle_share();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 8;
      2: return 20;
      default: return 40;
    endcase
  endfunction

  task clear_predictor();
    seen_valid = 1'b0;
    seen_store = 1'b0;
    seen_offset = '0;
    seen_size = '0;
    run_dir = 1'b0;
    run_sz = '0;
    run_next = '0;
    run_len = '0;
    tally = '0;
  endtask

  task close_run();
    logic [arcc_pkg::CNT_W-1:0] pairs;
    if (run_len >= 2) begin
      pairs = run_len >> 1;
      tally.sequences = sat_sum(tally.sequences, arcc_pkg::CNT_W'(1));
      if (run_dir) begin
        tally.st_pairs = sat_sum(tally.st_pairs, pairs);
      end else begin
        tally.ld_pairs = sat_sum(tally.ld_pairs, pairs);
      end
      tally.saved_count = sat_sum(tally.saved_count, pairs);
    end
    run_len = '0;
  endtask

  task fold_instruction(input arcc_pkg::item_t w, output bit has_result,
                        output arcc_pkg::counts_t res);
    bit grow;
    if (!w.is_access) begin
      close_run();
      seen_valid = 1'b0;
    end else begin
      // A store right after a load of the same field is only redundant when it
      // writes back the loaded value.
      if (seen_valid && seen_offset == w.offset && seen_size == w.size_bytes &&
          (seen_store || !w.is_store || w.stores_prior_load)) begin
        tally.repeat_hits = sat_sum(tally.repeat_hits, arcc_pkg::CNT_W'(1));
        tally.saved_count = sat_sum(tally.saved_count, arcc_pkg::CNT_W'(1));
      end
      grow = run_len != 0 && w.is_store == run_dir && w.size_bytes == run_sz &&
             pairable_size(w.size_bytes) && {1'b0, w.offset} == run_next;
      if (grow) begin
        run_len = sat_sum(run_len, arcc_pkg::CNT_W'(1));
        run_next = run_next + arcc_pkg::NEXT_W'(w.size_bytes);
      end else begin
        close_run();
        run_dir = w.is_store;
        run_sz = w.size_bytes;
        run_next = {1'b0, w.offset} + arcc_pkg::NEXT_W'(w.size_bytes);
        run_len = pairable_size(w.size_bytes) ? arcc_pkg::CNT_W'(1) : '0;
      end
      seen_valid = 1'b1;
      seen_store = w.is_store;
      seen_offset = w.offset;
      seen_size = w.size_bytes;
    end
    has_result = w.last;
    res = '0;
    if (w.last) begin
      close_run();
      res = tally;
      clear_predictor();
    end
  endtask

  task add_word(input int acc, input int st, input logic [arcc_pkg::OFFSET_WIDTH-1:0] off,
                input logic [arcc_pkg::SIZE_W-1:0] sz, input int spl, input int lst);
    arcc_pkg::item_t w;
    w.is_access = acc[0];
    w.is_store = st[0];
    w.offset = off;
    w.size_bytes = sz;
    w.stores_prior_load = spl[0];
    w.last = lst[0];
    pending.insert(pending.size(), w);
  endtask

  task flag_error(input string msg);
    if (mismatches < 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task check_field(input string name, input logic [arcc_pkg::CNT_W-1:0] exp_v,
                   input logic [arcc_pkg::CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      flag_error($sformatf("%s expected %0d, got %0d", name, exp_v, act_v));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        fold_instruction(on_bus, emitted, predicted);
        if (emitted) begin
          block_counts.insert(block_counts.size(), predicted);
        end
      end
      src_tick++;
      if (src_tick % 128 == 0) begin
        src_pct = idle_share();
      end
      quiet <= pending.size() < 150;
      if (!(in_valid && !in_ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < src_pct) begin
          src_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          on_bus = pending.pop_front();
          in_valid <= 1'b1;
          in_is_access <= on_bus.is_access;
          in_is_store <= on_bus.is_store;
          in_offset <= on_bus.offset;
          in_size_bytes <= on_bus.size_bytes;
          in_stores_prior_load <= on_bus.stores_prior_load;
          in_last <= on_bus.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_counts.sequences = out_sequences;
        seen_counts.ld_pairs = out_ld_pairs;
        seen_counts.st_pairs = out_st_pairs;
        seen_counts.repeat_hits = out_repeat_hits;
        seen_counts.saved_count = out_saved_count;
        if (block_counts.size() == 0) begin
          flag_error($sformatf("unexpected result word %0d %0d %0d %0d %0d",
                               out_sequences, out_ld_pairs, out_st_pairs,
                               out_repeat_hits, out_saved_count));
        end else begin
          want = block_counts.pop_front();
          check_field("sequences", want.sequences, seen_counts.sequences);
          check_field("ld_pairs", want.ld_pairs, seen_counts.ld_pairs);
          check_field("st_pairs", want.st_pairs, seen_counts.st_pairs);
          check_field("repeat_hits", want.repeat_hits, seen_counts.repeat_hits);
          check_field("saved_count", want.saved_count, seen_counts.saved_count);
        end
      end
      snk_tick++;
      if (snk_tick % 128 == 64) begin
        snk_pct = idle_share();
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < snk_pct) begin
        snk_gap = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int k;
    int len;
    int mark;
    int goal;
    int st;
    logic [arcc_pkg::OFFSET_WIDTH-1:0] off;
    logic [arcc_pkg::SIZE_W-1:0] sz;
    clear_predictor();

    add_word(1, 0, 16'h0000, arcc_pkg::SIZE_WORD, 0, 0);
    add_word(1, 0, 16'h0004, arcc_pkg::SIZE_WORD, 0, 0);
    add_word(1, 0, 16'h0008, arcc_pkg::SIZE_WORD, 0, 0);
    add_word(1, 0, 16'h0008, arcc_pkg::SIZE_WORD, 0, 0);
    add_word(1, 1, 16'h0008, arcc_pkg::SIZE_WORD, 0, 0);
    add_word(1, 0, 16'h0008, arcc_pkg::SIZE_WORD, 1, 0);
    add_word(1, 1, 16'h0008, arcc_pkg::SIZE_WORD, 1, 0);
    add_word(1, 1, 16'h0008, arcc_pkg::SIZE_WORD, 0, 0);
    add_word(1, 0, 16'hFFFF, 5'd0, 0, 0);
    add_word(1, 0, 16'hFFFF, 5'd0, 0, 0);
    add_word(1, 1, 16'h1234, 5'd1, 1, 0);
    add_word(1, 1, 16'h1235, 5'd2, 0, 0);
    add_word(1, 0, 16'h1237, 5'd31, 1, 0);
    add_word(1, 1, 16'hFFF0, arcc_pkg::SIZE_QWORD, 0, 0);
    add_word(1, 1, 16'h0000, arcc_pkg::SIZE_QWORD, 0, 0);
    add_word(1, 1, 16'h0010, arcc_pkg::SIZE_QWORD, 1, 0);
    add_word(0, 1, 16'hFFFF, 5'd31, 1, 1);
    add_word(1, 1, 16'h0020, arcc_pkg::SIZE_DWORD, 0, 0);
    add_word(1, 1, 16'h0028, arcc_pkg::SIZE_DWORD, 0, 1);
    add_word(1, 0, 16'h0040, arcc_pkg::SIZE_DWORD, 1, 1);

    mark = pending.size();
    while (pending.size() - mark < 1030) begin
      goal = pending.size() + $urandom_range(1, 40);
      while (pending.size() < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            st = int'($urandom_range(0, 1));
            sz = pick_pairable();
            off = random_offset();
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++) begin
              add_word(1, st, off, sz, int'($urandom_range(0, 1)), 0);
              off = off + 16'(sz);
            end
          end
          4, 5: begin
            off = random_offset();
            sz = $urandom_range(0, 1) ? pick_pairable() :
                 arcc_pkg::SIZE_W'($urandom_range(0, 31));
            len = $urandom_range(2, 4);
            for (k = 0; k < len; k++) begin
              add_word(1, int'($urandom_range(0, 1)), off, sz,
                       int'($urandom_range(0, 1)), 0);
            end
          end
          6: begin
            add_word(0, int'($urandom_range(0, 1)), 16'($urandom),
                     arcc_pkg::SIZE_W'($urandom_range(0, 31)),
                     int'($urandom_range(0, 1)), 0);
          end
          default: begin
            add_word(1, int'($urandom_range(0, 1)), 16'($urandom),
                     arcc_pkg::SIZE_W'($urandom_range(0, 31)),
                     int'($urandom_range(0, 1)), 0);
          end
        endcase
      end
      pending[pending.size() - 1].last = 1'b1;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (block_counts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("access_run_coalesce_counter_unit verification clean");
    end else begin
      $display("access_run_coalesce_counter_unit verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("access_run_coalesce_counter_unit verification failed");
    $finish;
  end

endmodule
`default_nettype wire
